@@ hdl/hcbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 24;

  localparam int SYM_W   = 8;
  localparam int CODE_W  = 24;
  localparam int LEN_W   = 5;
  localparam int ADDR_W  = $clog2(NUM_SYMBOLS);
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = BYTE_W - 1;
  localparam int PCNT_W  = 3;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int CNT_W   = $clog2(ACC_W + 1);
  localparam int VBITS_W = 4;
  localparam int TOT_W   = 32;

  localparam logic [VBITS_W-1:0] FULL_BYTE = VBITS_W'(BYTE_W);

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_ENCODE = 2'd1,
    FN_FLUSH  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } tbl_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic encode;
    logic flush;
    logic sym_ok;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/hcbp_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hcbp_table (
  input  wire logic            clk,
  input  wire hcbp_pkg::tbl_wr_t wr,
  input  wire hcbp_pkg::tbl_rd_t rd,
  output hcbp_pkg::entry_t     rdata
);
  import hcbp_pkg::*;

  entry_t mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/hcbp_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hcbp_pkg::cmd_t                cmd,
  input  wire hcbp_pkg::entry_t              rdata,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic [hcbp_pkg::VBITS_W-1:0]       valid_bits,
  output logic [hcbp_pkg::TOT_W-1:0]         total_bits,
  output logic                               last
);
  import hcbp_pkg::*;

  state_t state, state_next;

  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              flushing;
  logic              sym_ok;
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  logic [TOT_W-1:0]  emitted;

  logic                      slot_free;
  logic                      have_byte;
  logic                      emit_fire;
  logic                      done;
  logic [ACC_W+BYTE_W-1:0]   ext;
  logic [BYTE_W-1:0]         ext_byte;
  logic [VBITS_W-1:0]        emit_bits;
  logic [TOT_W:0]            tot_sum;
  logic [TOT_W-1:0]          emitted_next;
  logic [CODE_W-1:0]         ld_word;
  logic [LEN_W-1:0]          ld_len;
  logic [PEND_W-1:0]         keep_mask;

  // shared byte extractor: top byte of the live window, or the flush byte
  // left-aligned with zero fill when fewer than eight bits remain
  assign ext      = {acc, {BYTE_W{1'b0}}} >> cnt;
  assign ext_byte = ext[BYTE_W-1:0];

  assign emit_bits = flushing ? VBITS_W'(cnt) : FULL_BYTE;
  assign tot_sum   = {1'b0, emitted} + (TOT_W + 1)'(emit_bits);
  assign emitted_next = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

  assign ld_word   = sym_ok ? rdata.word : '0;
  assign ld_len    = sym_ok ? rdata.len  : '0;
  assign keep_mask = PEND_W'((8'h01 << cnt[PCNT_W-1:0]) - 8'h01);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.encode) begin
          state_next = ST_LOAD;
        end else if (cmd.flush && pend_cnt != '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_LOAD: state_next = ST_EMIT;
      ST_EMIT: begin
        if ((flushing && emit_fire) || done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    slot_free = !out_valid || !out_stall;
    have_byte = flushing || (cnt >= CNT_W'(BYTE_W));
    emit_fire = (state == ST_EMIT) && have_byte && slot_free;
    done      = (state == ST_EMIT) && !have_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flushing  <= 1'b0;
      cnt       <= '0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_IDLE) begin
        if (cmd.encode) begin
          sym_ok <= cmd.sym_ok;
        end else if (cmd.flush) begin
          acc      <= ACC_W'(pend_bits);
          cnt      <= CNT_W'(pend_cnt);
          flushing <= 1'b1;
        end
      end

      if (state == ST_LOAD) begin
        acc      <= (ACC_W'(pend_bits) << ld_len) | ACC_W'(ld_word);
        cnt      <= CNT_W'(pend_cnt) + CNT_W'(ld_len);
        flushing <= 1'b0;
      end

      if (emit_fire) begin
        emitted    <= emitted_next;
        out_byte   <= ext_byte;
        valid_bits <= emit_bits;
        total_bits <= emitted_next;
        last       <= flushing || (cnt < CNT_W'(2 * BYTE_W));
        if (flushing) begin
          cnt       <= '0;
          pend_bits <= '0;
          pend_cnt  <= '0;
        end else begin
          cnt <= cnt - CNT_W'(BYTE_W);
        end
      end

      if (done) begin
        pend_bits <= acc[PEND_W-1:0] & keep_mask;
        pend_cnt  <= cnt[PCNT_W-1:0];
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/huffman_code_bit_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Huffman code bit packer.
// Input channel (in_valid / in_stall) carries func, symbol, code_word and
// code_len. func 0 writes one code table entry and leaves the block idle.
// func 1 encodes a symbol: it is accepted, its table entry is read and
// loaded, each full output byte (0 to 3) is emitted and the leftover bits
// are stored. func 2 flushes the leftover bits as one zero-padded byte, or
// emits nothing when nothing is pending. in_stall is high while an encode
// or flush is in progress.
// Output channel (out_valid / out_stall) carries out_byte, valid_bits,
// total_bits and last, one byte per transaction from a registered stage.
// While out_stall is high the held byte stays put and the sequencer waits.
// Reset clears the pending bits, the bit total and the output valid flag; the
// code table is not cleared and entries must be loaded before use.
module huffman_code_bit_packer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    func,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   code_word,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    code_len,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic [hcbp_pkg::VBITS_W-1:0]       valid_bits,
  output logic [hcbp_pkg::TOT_W-1:0]         total_bits,
  output logic                               last
);
  import hcbp_pkg::*;

  logic              accept;
  logic              sym_ok;
  logic              busy;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   word_mask;
  tbl_wr_t           wr;
  tbl_rd_t           rd;
  entry_t            rdata;
  cmd_t              cmd;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign sym_ok   = (32'(symbol) < NUM_SYMBOLS);

  // clamp the length and drop code bits above it before storing
  assign len_sat   = (32'(code_len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : code_len;
  assign word_mask = ((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1);

  always_comb begin
    wr.we         = accept && (func == FN_LOAD) && sym_ok;
    wr.addr       = ADDR_W'(symbol);
    wr.entry.word = code_word & word_mask[CODE_W-1:0];
    wr.entry.len  = len_sat;
    rd.re         = accept && (func == FN_ENCODE);
    rd.addr       = ADDR_W'(symbol);
    cmd.encode    = accept && (func == FN_ENCODE);
    cmd.flush     = accept && (func == FN_FLUSH);
    cmd.sym_ok    = sym_ok;
  end

  hcbp_table u_table (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  hcbp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rdata      (rdata),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .valid_bits (valid_bits),
    .total_bits (total_bits),
    .last       (last)
  );

  a_vbits_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bits >= 4'd1 && valid_bits <= FULL_BYTE))
    else $error("valid_bits out of range");

  a_partial_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_bits != FULL_BYTE) |-> last)
    else $error("partial byte not marked last");

  a_encode_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FN_ENCODE) |=> in_stall)
    else $error("encode transaction did not hold off input");

  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FN_LOAD) |=> !in_stall)
    else $error("table load left the block busy");

endmodule

`default_nettype wire
